/* src/btsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsa_pkg
// shared types and constants for the bounded top score archive
// ----------------------------------------------------------------------------
package btsa_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int REC_W    = 112;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic        [15:0] handle;
      logic signed [31:0] fitness;
      logic signed [31:0] novelty;
      logic        [31:0] generation;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MIN,
      ST_SHIFT,
      ST_PUT,
      ST_MAX,
      ST_OUT
   } state_type;

endpackage

/* src/btsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsa_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module btsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/bounded_top_score_archive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_top_score_archive
// archive of up to sixteen records in one ram, evicting the lowest score
// an insert runs a check, then per eviction round a score scan and a shift
// unless the victim is the new record, then a put unless the new record was
// evicted, a fitness scan and one result; the scans use the one ram read port;
// a query runs a fitness scan per result, or none when it wants none or none
// are held; busy is high for the whole item; rsp_strobe cannot be held
// reset clears the count and sets the limit to 16; the ram is not cleared
// ----------------------------------------------------------------------------
module bounded_top_score_archive
   import btsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [15:0]         req_program_handle,
   input  logic signed [31:0]  req_fitness_in,
   input  logic signed [31:0]  req_novelty_in,
   input  logic [31:0]         req_generation_in,
   input  logic [4:0]          req_want_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_max_entries,
   output logic                rsp_strobe,
   output logic [4:0]          rsp_stored_count,
   output logic                rsp_found,
   output logic [15:0]         rsp_handle_out,
   output logic signed [31:0]  rsp_fitness_out,
   output logic signed [31:0]  rsp_novelty_out,
   output logic [31:0]         rsp_generation_out,
   output logic                rsp_last
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [4:0]         max_ff;
   rec_type            newr_ff, newr_in;
   logic               alive_ff, alive_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rv_ff, rv_in;
   logic [IDX_W-1:0]   ri_ff, ri_in;
   logic               have_ff, have_in;
   logic signed [32:0] low_ff, low_in;
   logic [IDX_W-1:0]   bidx_ff, bidx_in;
   rec_type            best_ff, best_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   n_ff, n_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [REC_W-1:0]   mem_wd;
   logic [REC_W-1:0]   mem_rd;
   logic               issue;
   logic               scan_done;
   rec_type            rd_rec;
   logic signed [32:0] rd_score;
   logic signed [32:0] new_score;
   logic [CNT_W-1:0]   lim;
   logic [CNT_W:0]     total;
   logic               over;
   logic [CNT_W-1:0]   qn;
   logic               take_min;
   logic               evict_new;
   logic               take_max;
   logic               is_last;

   btsa_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (mem_rd)
   );

   assign rd_rec    = rec_type'(mem_rd);
   assign rd_score  = {rd_rec.fitness[31], rd_rec.fitness}
                    + {rd_rec.novelty[31], rd_rec.novelty};
   assign new_score = {newr_ff.fitness[31], newr_ff.fitness}
                    + {newr_ff.novelty[31], newr_ff.novelty};
   assign lim = (max_ff == '0) ? CNT_W'(1)
              : ((max_ff > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : max_ff);
   assign total = {1'b0, count_ff} + {{CNT_W{1'b0}}, alive_ff};
   assign over  = total > {1'b0, lim};
   assign qn    = (req_want_count > count_ff) ? count_ff : req_want_count;
   assign issue = (state_ff == ST_MIN || state_ff == ST_SHIFT || state_ff == ST_MAX)
                  && (idx_ff < count_ff);
   assign scan_done = !issue && !rv_ff;
   assign take_min  = rv_ff && (!have_ff || rd_score <= low_ff);
   assign evict_new = alive_ff && (!have_ff || new_score <= low_ff);
   assign take_max  = rv_ff && !used_ff[ri_ff]
                      && (!have_ff || rd_rec.fitness > best_ff.fitness);
   assign is_last   = ({1'b0, k_ff} + 6'd1) >= {1'b0, n_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_INSERT) begin
                  state_in = ST_CHECK;
               end else if (qn == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MAX;
               end
            end
         end
         ST_CHECK: begin
            if (over) begin
               state_in = ST_MIN;
            end else if (alive_ff) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_MAX;
            end
         end
         ST_MIN: begin
            if (scan_done) begin
               state_in = evict_new ? ST_CHECK : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (scan_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_PUT:  state_in = ST_MAX;
         ST_MAX: begin
            if (scan_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT:  state_in = is_last ? ST_IDLE : ST_MAX;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;
      newr_in  = newr_ff;
      alive_in = alive_ff;
      idx_in   = idx_ff;
      rv_in    = 1'b0;
      ri_in    = idx_ff[IDX_W-1:0];
      have_in  = have_ff;
      low_in   = low_ff;
      bidx_in  = bidx_ff;
      best_in  = best_ff;
      used_in  = used_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      mem_we   = 1'b0;
      mem_wa   = ri_ff - IDX_W'(1);
      mem_wd   = mem_rd;
      if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
         rv_in  = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            k_in    = '0;
            used_in = '0;
            have_in = 1'b0;
            idx_in  = '0;
            if (start) begin
               newr_in.handle     = req_program_handle;
               newr_in.fitness    = req_fitness_in;
               newr_in.novelty    = req_novelty_in;
               newr_in.generation = req_generation_in;
               alive_in = (req_opcode == OP_INSERT);
               n_in     = (req_opcode == OP_INSERT) ? CNT_W'(1) : qn;
            end
         end
         ST_CHECK: begin
            idx_in  = '0;
            have_in = 1'b0;
            k_in    = '0;
            used_in = '0;
            n_in    = CNT_W'(1);
         end
         ST_MIN: begin
            if (take_min) begin
               low_in  = rd_score;
               bidx_in = ri_ff;
               have_in = 1'b1;
            end
            if (scan_done) begin
               if (evict_new) begin
                  alive_in = 1'b0;
               end else begin
                  idx_in = {1'b0, bidx_ff} + CNT_W'(1);
               end
            end
         end
         ST_SHIFT: begin
            mem_we = rv_ff;
            if (scan_done) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = count_ff[IDX_W-1:0];
            mem_wd   = newr_ff;
            count_in = count_ff + CNT_W'(1);
            alive_in = 1'b0;
            idx_in   = '0;
            have_in  = 1'b0;
         end
         ST_MAX: begin
            if (take_max) begin
               best_in = rd_rec;
               bidx_in = ri_ff;
               have_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (have_ff) begin
               used_in[bidx_ff] = 1'b1;
            end
            k_in    = k_ff + CNT_W'(1);
            idx_in  = '0;
            have_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         max_ff   <= 5'd16;
         alive_ff <= 1'b0;
         rv_ff    <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         alive_ff <= alive_in;
         rv_ff    <= rv_in;
         have_ff  <= have_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_entries;
         end
      end
   end

   always_ff @(posedge clock) begin
      newr_ff <= newr_in;
      idx_ff  <= idx_in;
      ri_ff   <= ri_in;
      low_ff  <= low_in;
      bidx_ff <= bidx_in;
      best_ff <= best_in;
      used_ff <= used_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = (state_ff == ST_OUT);
   assign rsp_stored_count   = count_ff;
   assign rsp_found          = have_ff;
   assign rsp_handle_out     = have_ff ? best_ff.handle : '0;
   assign rsp_fitness_out    = have_ff ? best_ff.fitness : '0;
   assign rsp_novelty_out    = have_ff ? best_ff.novelty : '0;
   assign rsp_generation_out = have_ff ? best_ff.generation : '0;
   assign rsp_last           = is_last;

endmodule

/* tb/sv/btsa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsa_checker
// scoreboard for the archive: own copy of the records and the limit,
// predicted results compared field by field, oldest first
// ----------------------------------------------------------------------------
module btsa_checker
   import btsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_opcode,
   input  logic [15:0]        req_program_handle,
   input  logic signed [31:0] req_fitness_in,
   input  logic signed [31:0] req_novelty_in,
   input  logic [31:0]        req_generation_in,
   input  logic [4:0]         req_want_count,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [4:0]         csr_max_entries,
   input  logic               rsp_strobe,
   input  logic [4:0]         rsp_stored_count,
   input  logic               rsp_found,
   input  logic [15:0]        rsp_handle_out,
   input  logic signed [31:0] rsp_fitness_out,
   input  logic signed [31:0] rsp_novelty_out,
   input  logic [31:0]        rsp_generation_out,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic [4:0] stored_count;
      logic       found;
      rec_type    rec;
      logic       last;
   } answer_type;

   answer_type answer_queue[$];
   rec_type    archive[0:CAPACITY];
   int         held;
   logic [4:0] max_entries;

   function automatic longint score(rec_type r);
      return longint'(r.fitness) + longint'(r.novelty);
   endfunction

   function automatic void push_answer(logic found, rec_type r, logic last);
      answer_type a;
      a.stored_count = held[4:0];
      a.found        = found;
      a.rec          = found ? r : '0;
      a.last         = last;
      answer_queue = {answer_queue, a};
   endfunction

   task automatic archive_insert(rec_type r);
      int     lim, total, newpos, victim, best;
      longint low, s;
      bit     alive, have;
      lim = (max_entries < 1) ? 1 : (max_entries > CAPACITY) ? CAPACITY : max_entries;
      total = held;
      newpos = total;
      archive[newpos] = r;
      total++;
      alive = 1;
      while (total > lim) begin
         victim = 0;
         low = 0;
         have = 0;
         if (alive) begin
            victim = newpos;
            low = score(archive[newpos]);
            have = 1;
         end
         for (int i = 0; i < total; i++) begin
            if (alive && i == newpos) continue;
            s = score(archive[i]);
            if (!have || s < low || (s == low && !(alive && victim == newpos) && i > victim)) begin
               victim = i;
               low = s;
               have = 1;
            end
         end
         if (alive && victim == newpos) alive = 0;
         else if (alive && victim < newpos) newpos--;
         for (int i = victim; i + 1 < total; i++) archive[i] = archive[i + 1];
         total--;
      end
      held = total;
      best = 0;
      for (int i = 1; i < total; i++)
         if (archive[i].fitness > archive[best].fitness) best = i;
      push_answer(total != 0, archive[best], 1'b1);
   endtask

   task automatic archive_query(int want);
      bit taken[0:CAPACITY];
      int n, pick;
      bit have;
      n = (want > held) ? held : want;
      if (n == 0) begin
         push_answer(1'b0, '0, 1'b1);
         return;
      end
      foreach (taken[i]) taken[i] = 0;
      for (int k = 0; k < n; k++) begin
         pick = 0;
         have = 0;
         for (int i = 0; i < held; i++) begin
            if (taken[i]) continue;
            if (!have || archive[i].fitness > archive[pick].fitness) begin
               pick = i;
               have = 1;
            end
         end
         taken[pick] = 1;
         push_answer(1'b1, archive[pick], k + 1 == n);
      end
   endtask

   task automatic report(string field, longint exp_v, longint act_v);
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      rec_type    r;
      if (reset) begin
         held = 0;
         max_entries = 5'd16;
         answer_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (answer_queue.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               a = answer_queue.pop_front();
               if (rsp_stored_count !== a.stored_count)
                  report("stored_count", a.stored_count, rsp_stored_count);
               if (rsp_found !== a.found) report("found", a.found, rsp_found);
               if (rsp_handle_out !== a.rec.handle)
                  report("handle_out", a.rec.handle, rsp_handle_out);
               if (rsp_fitness_out !== a.rec.fitness)
                  report("fitness_out", a.rec.fitness, rsp_fitness_out);
               if (rsp_novelty_out !== a.rec.novelty)
                  report("novelty_out", a.rec.novelty, rsp_novelty_out);
               if (rsp_generation_out !== a.rec.generation)
                  report("generation_out", a.rec.generation, rsp_generation_out);
               if (rsp_last !== a.last) report("last", a.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready) max_entries = csr_max_entries;
         if (start && !busy) begin
            if (req_opcode == OP_INSERT) begin
               r.handle     = req_program_handle;
               r.fitness    = req_fitness_in;
               r.novelty    = req_novelty_in;
               r.generation = req_generation_in;
               archive_insert(r);
            end else begin
               archive_query(int'(req_want_count));
            end
         end
      end
      pending <= answer_queue.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      held = 0;
      max_entries = 5'd16;
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// directed and random inserts and queries under several record limits,
// with random gaps; verdict from the checker's failure and pending count
// ----------------------------------------------------------------------------
module tb_top;
   import btsa_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic               req_opcode = OP_INSERT;
   logic [15:0]        req_program_handle = '0;
   logic signed [31:0] req_fitness_in = '0;
   logic signed [31:0] req_novelty_in = '0;
   logic [31:0]        req_generation_in = '0;
   logic [4:0]         req_want_count = '0;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [4:0]         csr_max_entries = '0;
   logic               rsp_strobe;
   logic [4:0]         rsp_stored_count;
   logic               rsp_found;
   logic [15:0]        rsp_handle_out;
   logic signed [31:0] rsp_fitness_out;
   logic signed [31:0] rsp_novelty_out;
   logic [31:0]        rsp_generation_out;
   logic               rsp_last;
   int                 fail_count;
   int                 pending;
   int                 stall_cycles = 0;
   bit                 steady = 0;

   localparam int STALL_LIMIT = 20000;

   bounded_top_score_archive dut (.*);
   btsa_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send(logic op, logic [15:0] h, logic [31:0] f, logic [31:0] n,
                       logic [31:0] g, logic [4:0] want);
      while (!steady && $urandom_range(99) < 16) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_program_handle <= h;
      req_fitness_in <= f;
      req_novelty_in <= n;
      req_generation_in <= g;
      req_want_count <= want;
      do @(posedge clock); while (busy);
   endtask

   task automatic insert(logic [15:0] h, logic [31:0] f, logic [31:0] n, logic [31:0] g);
      send(OP_INSERT, h, f, n, g, 5'($urandom));
   endtask

   task automatic query(logic [4:0] want);
      send(OP_QUERY, 16'($urandom), $urandom, $urandom, $urandom, want);
   endtask

   task automatic set_limit(logic [4:0] value);
      start <= 0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_valid <= 1;
      csr_max_entries <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0: return $urandom_range(3) << 16;
         1: return -($urandom_range(3) << 16);
         2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 70) insert(16'($urandom), pick_value(), pick_value(), $urandom);
         else query(5'($urandom_range(99) < 80 ? $urandom_range(17) : $urandom_range(31)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty archive, extremes, ties
      query(0);
      query(16);
      insert(16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
      insert(16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
      insert(16'h1234, 32'h0001_0000, 32'h0001_0000, 32'h5);
      insert(16'h1235, 32'h0001_0000, 32'h0001_0000, 32'h6);
      insert(16'h1236, 32'h0002_0000, 32'h0000_0000, 32'h7);
      query(31);
      query(2);
      for (int i = 0; i < 12; i++) insert(16'(i), $urandom, $urandom, $urandom);
      query(16);
      set_limit(5'd3);
      insert(16'h00aa, 32'h0, 32'h0, 32'h1);
      query(16);
      set_limit(5'd0);
      insert(16'h00bb, 32'h8000_0000, 32'h0, 32'h2);
      insert(16'h00cc, 32'h7fff_ffff, 32'h0, 32'h3);
      query(1);
      query(0);

      set_limit(5'd1);
      random_items(30);
      set_limit(5'd31);
      steady = 1;
      random_items(60);
      steady = 0;
      set_limit(5'd5);
      random_items(50);
      set_limit(5'd16);
      random_items(60);
      set_limit(5'd2);
      random_items(30);
      start <= 0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
src/btsa_pkg.sv
src/btsa_ram.sv
src/bounded_top_score_archive.sv
tb/sv/btsa_checker.sv
tb/sv/tb_top.sv
